FILE: design/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants of the framed packet parser with checksum:
// parse phase codes, framing marks, status codes and the state/result structs.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int unsigned PhaseW = 3;

  // parse phase codes
  localparam logic [PhaseW-1:0] PH_HUNT  = 3'd0;
  localparam logic [PhaseW-1:0] PH_LENH  = 3'd1;
  localparam logic [PhaseW-1:0] PH_LENL  = 3'd2;
  localparam logic [PhaseW-1:0] PH_ID    = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA  = 3'd4;
  localparam logic [PhaseW-1:0] PH_END   = 3'd5;
  localparam logic [PhaseW-1:0] PH_CHECK = 3'd6;

  localparam logic [7:0] START_MARK = 8'hAB;
  localparam logic [7:0] END_MARK   = 8'hBA;
  localparam logic [7:0] GOOD_SUM   = 8'hFF;

  // frame status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_END = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [7:0]        length_high;
    logic [15:0]       declared_length;
    logic [7:0]        current_id;
    logic [15:0]       data_remaining;
    logic [15:0]       running_sum;
  } parse_state_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
  } parse_result_t;

endpackage

FILE: design/fpp_if.sv
// ----------------------------------------------------------------------------
// fpp_rx_if / fpp_res_if
// Valid/ready channels of the frame parser: received bytes in, results out.
// ----------------------------------------------------------------------------
interface fpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_res_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        frame_done;
  logic [1:0]  frame_status;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;

  modport source (output valid, output payload_valid, output payload_byte,
                  output frame_done, output frame_status, output frame_id,
                  output frame_length, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input frame_done, input frame_status, input frame_id,
                  input frame_length, output ready);
endinterface

FILE: design/fpp_parse_core.sv
// ----------------------------------------------------------------------------
// fpp_parse_core
// Next-state and result logic of the frame parser for one received byte.
// ----------------------------------------------------------------------------
module fpp_parse_core (
  input  fpp_pkg::parse_state_t  state_i,
  input  logic [7:0]             rx_byte_i,
  output fpp_pkg::parse_state_t  state_o,
  output fpp_pkg::parse_result_t result_o
);

  fpp_pkg::parse_state_t nxt;
  logic [15:0] sum_add;
  logic [15:0] rem_dec;
  logic [7:0]  folded;
  logic        pv;
  logic        done;
  logic [1:0]  status;

  assign sum_add = state_i.running_sum + {8'd0, rx_byte_i};
  assign rem_dec = state_i.data_remaining - 16'd1;
  // end-around fold of the sum, only the low byte matters
  assign folded  = sum_add[15:8] + sum_add[7:0];

  always_comb begin
    nxt    = state_i;
    pv     = 1'b0;
    done   = 1'b0;
    status = fpp_pkg::ST_GOOD;
    case (state_i.phase)
      fpp_pkg::PH_LENH: begin
        nxt.length_high = rx_byte_i;
        nxt.phase       = fpp_pkg::PH_LENL;
      end
      fpp_pkg::PH_LENL: begin
        nxt.declared_length = {state_i.length_high, rx_byte_i};
        nxt.phase           = fpp_pkg::PH_ID;
      end
      fpp_pkg::PH_ID: begin
        nxt.current_id     = rx_byte_i;
        nxt.running_sum    = sum_add;
        nxt.data_remaining = state_i.declared_length;
        nxt.phase = (state_i.declared_length == 16'd0) ? fpp_pkg::PH_END
                                                       : fpp_pkg::PH_DATA;
      end
      fpp_pkg::PH_DATA: begin
        pv                 = 1'b1;
        nxt.running_sum    = sum_add;
        nxt.data_remaining = rem_dec;
        if (rem_dec == 16'd0) begin
          nxt.phase = fpp_pkg::PH_END;
        end
      end
      fpp_pkg::PH_END: begin
        if (rx_byte_i == fpp_pkg::END_MARK) begin
          nxt.phase = fpp_pkg::PH_CHECK;
        end else begin
          done      = 1'b1;
          status    = fpp_pkg::ST_BAD_END;
          nxt.phase = fpp_pkg::PH_HUNT;
        end
      end
      fpp_pkg::PH_CHECK: begin
        nxt.running_sum = sum_add;
        done            = 1'b1;
        status = (folded == fpp_pkg::GOOD_SUM) ? fpp_pkg::ST_GOOD : fpp_pkg::ST_BAD_SUM;
        nxt.phase       = fpp_pkg::PH_HUNT;
      end
      default: begin
        // hunting; unused codes also fall back here
        nxt.phase = fpp_pkg::PH_HUNT;
        if (rx_byte_i == fpp_pkg::START_MARK) begin
          nxt.length_high     = 8'd0;
          nxt.declared_length = 16'd0;
          nxt.current_id      = 8'd0;
          nxt.data_remaining  = 16'd0;
          nxt.running_sum     = 16'd0;
          nxt.phase           = fpp_pkg::PH_LENH;
        end
      end
    endcase
  end

  assign state_o                = nxt;
  assign result_o.payload_valid = pv;
  assign result_o.payload_byte  = pv ? rx_byte_i : 8'd0;
  assign result_o.frame_done    = done;
  assign result_o.frame_status  = status;
  assign result_o.frame_id      = nxt.current_id;
  assign result_o.frame_length  = nxt.declared_length;

endmodule

FILE: design/framed_packet_parser_checksum_unit.sv
// ----------------------------------------------------------------------------
// framed_packet_parser_checksum_unit
// Parses length-prefixed frames (0xAB, length, id, data, 0xBA, checksum) from
// a byte stream and reports data bytes and frame status, one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i  : one received byte per transaction (valid/ready).
//   res_o : exactly one result per accepted byte, in order: payload byte
//           with payload_valid, frame_done/frame_status at the end of a
//           frame, and the id and length of the current or last frame.
// Path: an accepted byte lands in the input register, and its result is
//   then held in the result register.
// Throughput: one byte per cycle unless res_o stalls; the parse state
//   advances as a byte moves from the input register to the result register.
// Stall: when res_o.ready is low the result register holds and the input
//   register fills; rx_i.ready drops only when both are occupied and the
//   receiver still stalls.
// Reset: rst_ni clears both stages and returns the parser to hunting for a
//   start byte with id, length and checksum sum cleared.
// ----------------------------------------------------------------------------
module framed_packet_parser_checksum_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpp_rx_if.sink    rx_i,
  fpp_res_if.source res_o
);

  logic                   in_v_q;
  logic [7:0]             in_byte_q;
  logic                   out_v_q;
  fpp_pkg::parse_result_t out_q;
  fpp_pkg::parse_state_t  st_q, st_d;
  fpp_pkg::parse_result_t res_d;
  logic                   adv;

  // result register may load when empty or being drained
  assign adv        = !out_v_q || res_o.ready;
  assign rx_i.ready = !in_v_q || adv;

  fpp_parse_core u_core (
    .state_i   (st_q),
    .rx_byte_i (in_byte_q),
    .state_o   (st_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= '0;
    end else begin
      if (rx_i.ready) begin
        in_v_q <= rx_i.valid;
      end
      if (adv) begin
        out_v_q <= in_v_q;
        if (in_v_q) begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (adv && in_v_q) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid         = out_v_q;
  assign res_o.payload_valid = out_q.payload_valid;
  assign res_o.payload_byte  = out_q.payload_byte;
  assign res_o.frame_done    = out_q.frame_done;
  assign res_o.frame_status  = out_q.frame_status;
  assign res_o.frame_id      = out_q.frame_id;
  assign res_o.frame_length  = out_q.frame_length;

  // a data byte in the input stage becomes a payload result
  a_data_to_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && adv && st_q.phase == fpp_pkg::PH_DATA) |=> (out_v_q && out_q.payload_valid))
    else $error("data-phase byte did not produce a payload result");

  // a frame end is never also a payload byte
  a_done_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.frame_done) |-> !out_q.payload_valid)
    else $error("frame end flagged as payload");

  // a non-good status only comes with frame_done
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.frame_status != fpp_pkg::ST_GOOD) |-> out_q.frame_done)
    else $error("frame status set without frame end");

  // input back-pressure only when the input stage is occupied and stalled
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_v_q && out_v_q && !res_o.ready))
    else $error("input stalled without a full pipeline");

  // the parse state only moves when a byte leaves the input stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_v_q && adv) |=> $stable(st_q))
    else $error("parse state changed without a byte");

endmodule
